### hw/rtl/tis_pkg.sv
// tis_pkg: shared types and constants of the track isolation sum unit.
// Used by the configuration registers, the controller and the datapath.
package tis_pkg;

  // Field widths
  localparam int unsigned SumW  = 26;
  localparam int unsigned IsoW  = 32;
  localparam int unsigned MagW  = 32;                // |numerator| of the final division
  localparam int unsigned DenW  = 6;                 // |40 - cone_tenths|

  localparam logic [SumW-1:0] SumMax   = {SumW{1'b1}};
  localparam logic signed [13:0] PhiHalf = 14'sd3217;
  localparam logic signed [13:0] PhiFull = 14'sd6434;

  // One quotient bit per divider step
  localparam int unsigned DivSteps = MagW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register values
  typedef struct packed {
    logic [5:0]  cone_tenths;
    logic [15:0] pt_threshold;
    logic [11:0] inner_radius;
    logic [2:0]  quality_select;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a track transfer
    logic square;     // squares and strip test
    logic sum;        // d2 = deta^2 + dphi^2
    logic accum;      // cone and veto test, accumulate
    logic mul;        // numerator products
    logic div_init;   // signs and magnitudes
    logic div_step;   // one restoring division step
    logic out_load;   // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;       // captured track closes the candidate
  } sts_t;

endpackage

### hw/rtl/tis_cfg_regs.sv
// tis_cfg_regs: APB-style configuration registers of the track isolation unit.
// Depends on tis_pkg for cfg_t.
module tis_cfg_regs
  import tis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  localparam logic [1:0] RegCone  = 2'd0;
  localparam logic [1:0] RegPtThr = 2'd1;
  localparam logic [1:0] RegInner = 2'd2;
  localparam logic [1:0] RegQual  = 2'd3;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cone_tenths    <= 6'd4;
      cfg_q.pt_threshold   <= 16'd0;
      cfg_q.inner_radius   <= 12'd0;
      cfg_q.quality_select <= 3'd0;
    end else if (wr_en) begin
      case (reg_idx)
        RegCone:  cfg_q.cone_tenths    <= pwdata[5:0];
        RegPtThr: cfg_q.pt_threshold   <= pwdata[15:0];
        RegInner: cfg_q.inner_radius   <= pwdata[11:0];
        RegQual:  cfg_q.quality_select <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      RegCone:  prdata = {26'd0, cfg_q.cone_tenths};
      RegPtThr: prdata = {16'd0, cfg_q.pt_threshold};
      RegInner: prdata = {20'd0, cfg_q.inner_radius};
      RegQual:  prdata = {29'd0, cfg_q.quality_select};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/tis_ctrl.sv
// tis_ctrl: sequencer of the track isolation unit; steps the datapath per track
// and runs the divider on the last track. Depends on tis_pkg for cmd_t, sts_t.
module tis_ctrl
  import tis_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StSum,
    StAccum,
    StMul,
    StDivInit,
    StDiv,
    StDone
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   step_cnt_q;
  logic                 out_valid_q;
  logic                 in_xfer;
  logic                 out_free;

  assign in_ready_o  = (state_q == StIdle);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;

  // Commands decoded from the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_xfer;
    cmd_o.square   = (state_q == StSquare);
    cmd_o.sum      = (state_q == StSum);
    cmd_o.accum    = (state_q == StAccum);
    cmd_o.mul      = (state_q == StMul);
    cmd_o.div_init = (state_q == StDivInit);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.out_load = (state_q == StDone) & out_free;
  end

  // State, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            state_q <= StSquare;
          end
        end
        StSquare:  state_q <= StSum;
        StSum:     state_q <= StAccum;
        StAccum: begin
          state_q <= sts_i.last ? StMul : StIdle;
        end
        StMul:     state_q <= StDivInit;
        StDivInit: begin
          step_cnt_q <= '0;
          state_q    <= StDiv;
        end
        StDiv: begin
          step_cnt_q <= step_cnt_q + 1'b1;
          if (step_cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default:   state_q <= StIdle;
      endcase
    end
  end

endmodule

### hw/rtl/tis_datapath.sv
// tis_datapath: geometry, accumulators, numerator products, restoring divider
// and result register of the track isolation unit. Depends on tis_pkg.
module tis_datapath
  import tis_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic signed [13:0]     cand_eta_i,
  input  logic signed [12:0]     cand_phi_i,
  input  logic [15:0]            track_pt_i,
  input  logic signed [13:0]     track_eta_i,
  input  logic signed [12:0]     track_phi_i,
  input  logic [7:0]             track_quality_bits_i,
  input  logic                   last_track_i,
  output logic [SumW-1:0]        cone_sum_o,
  output logic [SumW-1:0]        strip_sum_o,
  output logic signed [IsoW-1:0] corrected_iso_o
);

  // Captured track
  logic signed [14:0] deta_q, deta_d;
  logic signed [13:0] dphi_q, dphi_d, dphi_raw;
  logic [15:0]        pt_q;
  logic               pass_q, pass_d;
  logic               last_q;

  // Squares and tests
  logic signed [29:0] deta_prod;
  logic signed [27:0] dphi_prod;
  logic [28:0]        deta_sq_q, dphi_sq_q;
  logic [23:0]        inner2_q;
  logic [11:0]        xsq_q;
  logic [14:0]        adeta;
  logic               strip_ok_q, strip_ok_d;
  logic [29:0]        d2_q;
  logic [36:0]        d2_x100;
  logic               cone_ok, veto_ok;

  // Accumulators
  logic [SumW-1:0]    cone_acc_q, strip_acc_q;
  logic [SumW-1:0]    cone_nxt, strip_nxt;
  logic [SumW-1:0]    cone_fin_q, strip_fin_q;
  logic [SumW:0]      cone_add, strip_add;

  // Division
  logic [31:0]        prod_a_q, prod_b_q;
  logic [32:0]        num;
  logic signed [6:0]  den;
  logic [MagW-1:0]    quo_q;
  logic [DenW-1:0]    rem_q, den_mag_q;
  logic [DenW:0]      rem_sh;
  logic               q_neg_q, den_zero_q;
  logic signed [IsoW-1:0] iso_d;

  logic [SumW-1:0]    cone_sum_q, strip_sum_q;
  logic signed [IsoW-1:0] iso_q;

  assign sts_o.last      = last_q;
  assign cone_sum_o      = cone_sum_q;
  assign strip_sum_o     = strip_sum_q;
  assign corrected_iso_o = iso_q;

  // Differences with a single phi wrap, track selection
  always_comb begin
    deta_d   = $signed({track_eta_i[13], track_eta_i}) - $signed({cand_eta_i[13], cand_eta_i});
    dphi_raw = $signed({track_phi_i[12], track_phi_i}) - $signed({cand_phi_i[12], cand_phi_i});
    if (dphi_raw > PhiHalf) begin
      dphi_d = dphi_raw - PhiFull;
    end else if (dphi_raw < -PhiHalf) begin
      dphi_d = dphi_raw + PhiFull;
    end else begin
      dphi_d = dphi_raw;
    end
    pass_d = track_quality_bits_i[cfg_i.quality_select] & (track_pt_i > cfg_i.pt_threshold);
  end

  // Squares and strip test
  always_comb begin
    deta_prod  = deta_q * deta_q;
    dphi_prod  = dphi_q * dphi_q;
    adeta      = deta_q[14] ? 15'(-deta_q) : 15'(deta_q);
    strip_ok_d = ({3'd0, adeta} * 18'd10) < {2'd0, cfg_i.cone_tenths, 10'd0};
  end

  // Cone and veto tests, saturating adds
  always_comb begin
    d2_x100   = {7'd0, d2_q} * 37'd100;
    cone_ok   = d2_x100 < {5'd0, xsq_q, 20'd0};
    veto_ok   = d2_q >= {6'd0, inner2_q};
    cone_add  = {1'b0, cone_acc_q} + {{(SumW-15){1'b0}}, pt_q};
    strip_add = {1'b0, strip_acc_q} + {{(SumW-15){1'b0}}, pt_q};
    cone_nxt  = cone_acc_q;
    strip_nxt = strip_acc_q;
    if (pass_q && veto_ok) begin
      if (cone_ok) begin
        cone_nxt = cone_add[SumW] ? SumMax : cone_add[SumW-1:0];
      end
      if (strip_ok_q) begin
        strip_nxt = strip_add[SumW] ? SumMax : strip_add[SumW-1:0];
      end
    end
  end

  // Numerator and denominator
  always_comb begin
    num    = {1'b0, prod_a_q} - {1'b0, prod_b_q};
    den    = 7'sd40 - $signed({1'b0, cfg_i.cone_tenths});
    rem_sh = {rem_q, quo_q[MagW-1]};
  end

  // Signed, saturated quotient; zero when the denominator is zero
  always_comb begin
    if (den_zero_q) begin
      iso_d = '0;
    end else if (q_neg_q) begin
      iso_d = (quo_q > 32'h8000_0000) ? $signed(32'h8000_0000) : $signed(-quo_q);
    end else begin
      iso_d = (quo_q > 32'h7FFF_FFFF) ? $signed(32'h7FFF_FFFF) : $signed(quo_q);
    end
  end

  // Accumulators are the only state that reset clears here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cone_acc_q  <= '0;
      strip_acc_q <= '0;
    end else if (cmd_i.accum) begin
      cone_acc_q  <= last_q ? '0 : cone_nxt;
      strip_acc_q <= last_q ? '0 : strip_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deta_q <= deta_d;
      dphi_q <= dphi_d;
      pt_q   <= track_pt_i;
      pass_q <= pass_d;
      last_q <= last_track_i;
    end
    if (cmd_i.square) begin
      deta_sq_q  <= deta_prod[28:0];
      dphi_sq_q  <= {2'd0, dphi_prod[26:0]};
      inner2_q   <= cfg_i.inner_radius * cfg_i.inner_radius;
      xsq_q      <= cfg_i.cone_tenths * cfg_i.cone_tenths;
      strip_ok_q <= strip_ok_d;
    end
    if (cmd_i.sum) begin
      d2_q <= {1'b0, deta_sq_q} + {1'b0, dphi_sq_q};
    end
    if (cmd_i.accum) begin
      cone_fin_q  <= cone_nxt;
      strip_fin_q <= strip_nxt;
    end
    if (cmd_i.mul) begin
      prod_a_q <= {6'd0, cone_fin_q} * 32'd40;
      prod_b_q <= {6'd0, strip_fin_q} * {26'd0, cfg_i.cone_tenths};
    end
    if (cmd_i.div_init) begin
      quo_q      <= num[32] ? 32'(-num) : num[31:0];
      rem_q      <= '0;
      den_mag_q  <= den[6] ? 6'(-den) : den[5:0];
      den_zero_q <= (den == 7'sd0);
      q_neg_q    <= num[32] ^ den[6];
    end
    // Restoring division, one quotient bit per step
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_mag_q}) begin
        rem_q <= DenW'(rem_sh - {1'b0, den_mag_q});
        quo_q <= {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DenW-1:0];
        quo_q <= {quo_q[MagW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      cone_sum_q  <= cone_fin_q;
      strip_sum_q <= strip_fin_q;
      iso_q       <= iso_d;
    end
  end

endmodule

### hw/rtl/track_isolation_sum_unit.sv
// track_isolation_sum_unit: top level of the track isolation sum block.
// Instantiates tis_cfg_regs, tis_ctrl and tis_datapath; depends on tis_pkg.
//
// Tracks of one candidate arrive one transfer at a time; each selected track
// adds its pt to a saturating cone-annulus sum and an eta-strip sum. A track
// occupies the block through capture, squares, d2 sum, and test and
// accumulate; in_ready_o stays low until the block is through with it.
// The track marked last additionally runs the numerator products and a
// restoring divider that produces one quotient bit per cycle, then waits
// for the result register to empty. The result register holds cone_sum,
// strip_sum and corrected_iso until its transfer; the next candidate's
// tracks are taken while it waits. Configuration must be written over the
// APB-style port only while the block is idle; the block does not enforce it.
module track_isolation_sum_unit
  import tis_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // track input
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [13:0]     cand_eta_i,
  input  logic signed [12:0]     cand_phi_i,
  input  logic [15:0]            track_pt_i,
  input  logic signed [13:0]     track_eta_i,
  input  logic signed [12:0]     track_phi_i,
  input  logic [7:0]             track_quality_bits_i,
  input  logic                   last_track_i,
  // result output
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SumW-1:0]        cone_sum_o,
  output logic [SumW-1:0]        strip_sum_o,
  output logic signed [IsoW-1:0] corrected_iso_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tis_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tis_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cand_eta_i           (cand_eta_i),
    .cand_phi_i           (cand_phi_i),
    .track_pt_i           (track_pt_i),
    .track_eta_i          (track_eta_i),
    .track_phi_i          (track_phi_i),
    .track_quality_bits_i (track_quality_bits_i),
    .last_track_i         (last_track_i),
    .cone_sum_o           (cone_sum_o),
    .strip_sum_o          (strip_sum_o),
    .corrected_iso_o      (corrected_iso_o)
  );

endmodule

### hw/rtl/tis_checker.sv
// tis_checker: port-level assertions for track_isolation_sum_unit, bound to it.
// Depends on tis_pkg for field widths.
module tis_checker
  import tis_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pready,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SumW-1:0]        cone_sum_o,
  input logic [SumW-1:0]        strip_sum_o,
  input logic signed [IsoW-1:0] corrected_iso_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cone_sum_o) && $stable(strip_sum_o)
      && $stable(corrected_iso_o))
    else $error("result payload changed while stalled");

  // A track transfer keeps the block busy in the following cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  // Configuration port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind track_isolation_sum_unit tis_checker u_tis_checker (.*);

### sim/track_isolation_sum_unit_tb.sv
`timescale 1ns / 100ps
// track_isolation_sum_unit_tb: self-checking testbench of the track isolation sum unit.
// Holds a transfer-level model of the cone and strip sums; depends on tis_pkg and the RTL.

import tis_pkg::*;

// one track transfer as driven on the input channel
typedef struct {
  logic signed [13:0] cand_eta;
  logic signed [12:0] cand_phi;
  logic [15:0]        pt;
  logic signed [13:0] track_eta;
  logic signed [12:0] track_phi;
  logic [7:0]         quality;
  logic               last;
} track_t;

// one candidate result
typedef struct {
  logic [SumW-1:0]        cone;
  logic [SumW-1:0]        strip;
  logic signed [IsoW-1:0] iso;
} iso_result_t;

typedef enum int unsigned {
  REG_CONE_TENTHS    = 0,
  REG_PT_THRESHOLD   = 1,
  REG_INNER_RADIUS   = 2,
  REG_QUALITY_SELECT = 3
} reg_idx_e;

// Tracks the register copy and both sums; queues the result of every closed candidate.
class iso_scoreboard;
  cfg_t        cfg;
  longint      cone_acc;
  longint      strip_acc;
  iso_result_t pending_sums[$];
  int unsigned errors;
  int unsigned tracks_seen;
  int unsigned results_seen;

  function new();
    cfg.cone_tenths    = 6'd4;
    cfg.pt_threshold   = 16'd0;
    cfg.inner_radius   = 12'd0;
    cfg.quality_select = 3'd0;
    cone_acc     = 0;
    strip_acc    = 0;
    errors       = 0;
    tracks_seen  = 0;
    results_seen = 0;
  endfunction

  function void set_reg(reg_idx_e idx, logic [31:0] value);
    case (idx)
      REG_CONE_TENTHS:    cfg.cone_tenths    = value[5:0];
      REG_PT_THRESHOLD:   cfg.pt_threshold   = value[15:0];
      REG_INNER_RADIUS:   cfg.inner_radius   = value[11:0];
      REG_QUALITY_SELECT: cfg.quality_select = value[2:0];
      default: ;
    endcase
  endfunction

  function longint sat_sum(longint acc, logic [15:0] pt);
    longint s;
    s = acc + longint'(pt);
    return (s > longint'(SumMax)) ? longint'(SumMax) : s;
  endfunction

  // Adds one accepted track; on the last one computes the corrected isolation.
  function void accumulate_track(track_t t);
    longint deta, dphi, d2, x, inner2, adeta, num, den, q;
    iso_result_t r;
    tracks_seen++;
    x = longint'(cfg.cone_tenths);
    if (t.quality[cfg.quality_select] && t.pt > cfg.pt_threshold) begin
      deta = longint'(t.track_eta) - longint'(t.cand_eta);
      dphi = longint'(t.track_phi) - longint'(t.cand_phi);
      // single wrap of the azimuth difference
      if (dphi > longint'(PhiHalf)) begin
        dphi = dphi - longint'(PhiFull);
      end else if (dphi < -longint'(PhiHalf)) begin
        dphi = dphi + longint'(PhiFull);
      end
      d2     = deta * deta + dphi * dphi;
      inner2 = longint'(cfg.inner_radius) * longint'(cfg.inner_radius);
      adeta  = (deta < 0) ? -deta : deta;
      if (d2 >= inner2) begin
        if (100 * d2 < x * x * 1048576) cone_acc = sat_sum(cone_acc, t.pt);
        if (10 * adeta < x * 1024) strip_acc = sat_sum(strip_acc, t.pt);
      end
    end
    if (t.last) begin
      den = 40 - x;
      q   = 0;
      // zero denominator gives zero; otherwise truncate toward zero and clamp
      if (den != 0) begin
        num = 40 * cone_acc - x * strip_acc;
        q   = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      r.cone  = cone_acc[SumW-1:0];
      r.strip = strip_acc[SumW-1:0];
      r.iso   = q[IsoW-1:0];
      pending_sums.push_back(r);
      cone_acc  = 0;
      strip_acc = 0;
    end
  endfunction

  task flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Compares one result transfer against the oldest queued candidate.
  task check_result(logic [SumW-1:0] cone, logic [SumW-1:0] strip,
                    logic signed [IsoW-1:0] iso);
    iso_result_t want;
    if (pending_sums.size() == 0) begin
      flag_mismatch($sformatf("result with none queued: cone %0d strip %0d iso %0d",
                              cone, strip, iso));
    end else begin
      want = pending_sums.pop_front();
      results_seen++;
      if (cone !== want.cone)
        flag_mismatch($sformatf("cone_sum %0d, want %0d", cone, want.cone));
      if (strip !== want.strip)
        flag_mismatch($sformatf("strip_sum %0d, want %0d", strip, want.strip));
      if (iso !== want.iso)
        flag_mismatch($sformatf("corrected_iso %0d, want %0d", iso, want.iso));
    end
  endtask
endclass

module track_isolation_sum_unit_tb;

  localparam int unsigned SettleCycles = 60;   // covers the last-track path through the divider
  localparam int unsigned TrackTarget  = 1360;
  localparam int unsigned LongStream   = 1060; // enough max-pt tracks to saturate both sums

  logic                   clk_i;
  logic                   rst_ni   = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [3:0]             paddr    = '0;
  logic [31:0]            pwdata   = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [13:0]     cand_eta_i = '0;
  logic signed [12:0]     cand_phi_i = '0;
  logic [15:0]            track_pt_i = '0;
  logic signed [13:0]     track_eta_i = '0;
  logic signed [12:0]     track_phi_i = '0;
  logic [7:0]             track_quality_bits_i = '0;
  logic                   last_track_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [SumW-1:0]        cone_sum_o;
  logic [SumW-1:0]        strip_sum_o;
  logic signed [IsoW-1:0] corrected_iso_o;

  iso_scoreboard sb;
  bit            no_idle = 1'b0;
  int unsigned   cfg_writes = 0;

  track_isolation_sum_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .cand_eta_i          (cand_eta_i),
    .cand_phi_i          (cand_phi_i),
    .track_pt_i          (track_pt_i),
    .track_eta_i         (track_eta_i),
    .track_phi_i         (track_phi_i),
    .track_quality_bits_i(track_quality_bits_i),
    .last_track_i        (last_track_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .cone_sum_o          (cone_sum_o),
    .strip_sum_o         (strip_sum_o),
    .corrected_iso_o     (corrected_iso_o)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] reg_mask(reg_idx_e idx);
    case (idx)
      REG_CONE_TENTHS:    return 32'h0000_003F;
      REG_PT_THRESHOLD:   return 32'h0000_FFFF;
      REG_INNER_RADIUS:   return 32'h0000_0FFF;
      REG_QUALITY_SELECT: return 32'h0000_0007;
      default:            return 32'h0;
    endcase
  endfunction

  function automatic track_t make_track(int ceta, int cphi, int pt, int teta, int tphi,
                                        int qual, bit last);
    track_t t;
    t.cand_eta  = 14'(ceta);
    t.cand_phi  = 13'(cphi);
    t.pt        = 16'(pt);
    t.track_eta = 14'(teta);
    t.track_phi = 13'(tphi);
    t.quality   = 8'(qual);
    t.last      = last;
    return t;
  endfunction

  // Setup then access phase; a write lands at the access edge, a read samples there.
  task automatic apb_access(input reg_idx_e idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 4'(idx << 2);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_expect(reg_idx_e idx, logic [31:0] want);
    logic [31:0] rdata;
    apb_access(idx, 1'b0, 32'h0, rdata);
    if (rdata !== want)
      sb.flag_mismatch($sformatf("register %s reads %0h, want %0h", idx.name(), rdata, want));
  endtask

  // Write with junk above the field, then read the field back.
  task automatic program_reg(reg_idx_e idx, int unsigned value);
    logic [31:0] mask, wdata, rdata;
    mask  = reg_mask(idx);
    wdata = (32'(value) & mask) | ($urandom() & ~mask);
    apb_access(idx, 1'b1, wdata, rdata);
    sb.set_reg(idx, wdata);
    cfg_writes++;
    reg_expect(idx, 32'(value) & mask);
  endtask

  task automatic configure(int unsigned cone, int unsigned thr, int unsigned inner,
                           int unsigned qsel);
    program_reg(REG_CONE_TENTHS, cone);
    program_reg(REG_PT_THRESHOLD, thr);
    program_reg(REG_INNER_RADIUS, inner);
    program_reg(REG_QUALITY_SELECT, qsel);
  endtask

  // Valid stays high across back-to-back transfers; it drops only for a gap.
  task automatic send_track(track_t t);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    cand_eta_i           <= t.cand_eta;
    cand_phi_i           <= t.cand_phi;
    track_pt_i           <= t.pt;
    track_eta_i          <= t.track_eta;
    track_phi_i          <= t.track_phi;
    track_quality_bits_i <= t.quality;
    last_track_i         <= t.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accumulate_track(t);
  endtask

  // Block idle: every result back and the pipeline flushed.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Track near the candidate most of the time so the cone and strip edges get hit.
  function automatic track_t random_track(logic signed [13:0] ceta, logic signed [12:0] cphi,
                                          logic last);
    track_t t;
    int     reach, p, thr;
    reach      = int'(sb.cfg.cone_tenths) * 103 + 64;
    t.cand_eta = ceta;
    t.cand_phi = cphi;
    t.last     = last;
    if ($urandom_range(0, 19) == 0) begin
      t.cand_eta = 14'($urandom());
      t.cand_phi = 13'($urandom());
    end
    if ($urandom_range(0, 9) == 0) begin
      t.track_eta = 14'($urandom());
      t.track_phi = 13'($urandom());
    end else begin
      t.track_eta = 14'(int'(t.cand_eta) + int'($urandom_range(0, 2 * reach)) - reach);
      p = int'(t.cand_phi) + int'($urandom_range(0, 2 * reach)) - reach;
      if ($urandom_range(0, 4) != 0) begin
        if (p > 3217) p = p - 6434;
        else if (p < -3217) p = p + 6434;
      end
      t.track_phi = 13'(p);
    end
    case ($urandom_range(0, 3))
      0: t.pt = 16'($urandom());
      1: begin
        thr  = int'(sb.cfg.pt_threshold) + int'($urandom_range(0, 4)) - 2;
        t.pt = (thr < 0) ? 16'd0 : (thr > 65535) ? 16'hFFFF : 16'(thr);
      end
      2: t.pt = 16'($urandom_range(0, 255));
      default: t.pt = 16'($urandom_range(40000, 65535));
    endcase
    t.quality = 8'($urandom());
    if ($urandom_range(0, 3) != 0) t.quality[sb.cfg.quality_select] = 1'b1;
    return t;
  endfunction

  // Result side: a random hold-off before each transfer.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(cone_sum_o, strip_sum_o, corrected_iso_o);
    end
  end

  // Stimulus
  initial begin
    int unsigned        cone, thr, inner, qsel, n, phase_tracks, phases;
    logic signed [13:0] ceta;
    logic signed [12:0] cphi;
    track_t             t;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register reset values
    reg_expect(REG_CONE_TENTHS, 32'd4);
    reg_expect(REG_PT_THRESHOLD, 32'd0);
    reg_expect(REG_INNER_RADIUS, 32'd0);
    reg_expect(REG_QUALITY_SELECT, 32'd0);

    // reset settings: quality, threshold, phi wrap, strip and cone edges, field extremes
    send_track(make_track(0, 0, 65535, 0, 0, 8'h01, 1'b0));
    send_track(make_track(0, 0, 1000, 0, 0, 8'hFE, 1'b0));
    send_track(make_track(0, 0, 0, 0, 0, 8'hFF, 1'b0));
    send_track(make_track(0, 3217, 500, 0, -3217, 8'h01, 1'b0));
    send_track(make_track(0, -3217, 700, 0, 3217, 8'h01, 1'b0));
    send_track(make_track(100, 0, 300, 509, 0, 8'h01, 1'b0));
    send_track(make_track(100, 0, 301, 510, 0, 8'h01, 1'b0));
    send_track(make_track(-8192, -4096, 65535, 8191, 4095, 8'hFF, 1'b1));
    send_track(make_track(5120, 3217, 1, -5120, -3217, 8'h01, 1'b1));
    drain();

    // denominator zero; pt equal to threshold is rejected
    configure(40, 100, 0, 7);
    send_track(make_track(0, 0, 101, 0, 0, 8'h80, 1'b0));
    send_track(make_track(0, 0, 100, 0, 0, 8'h80, 1'b0));
    send_track(make_track(0, 0, 65535, 200, -200, 8'h80, 1'b1));
    drain();

    // zero cone: nothing passes
    configure(0, 0, 0, 3);
    send_track(make_track(0, 0, 65535, 0, 0, 8'h08, 1'b0));
    send_track(make_track(10, 10, 5, 10, 10, 8'hFF, 1'b1));
    drain();

    // widest cone, full inner veto, negative denominator
    configure(63, 0, 4095, 5);
    send_track(make_track(0, 0, 1000, 4095, 0, 8'h20, 1'b0));
    send_track(make_track(0, 0, 1000, 4094, 0, 8'h20, 1'b0));
    send_track(make_track(-4000, 0, 2000, 2000, 1000, 8'h20, 1'b0));
    send_track(make_track(0, 0, 65535, 6452, 0, 8'h20, 1'b1));
    drain();

    // threshold at maximum: no pt can exceed it
    configure(39, 65535, 0, 0);
    send_track(make_track(0, 0, 65535, 0, 0, 8'hFF, 1'b1));
    drain();

    // narrowest cone: edges of cone and strip
    configure(1, 0, 0, 0);
    send_track(make_track(0, 0, 50, 102, 0, 8'h01, 1'b0));
    send_track(make_track(0, 0, 60, 0, 103, 8'h01, 1'b1));
    drain();

    // one long candidate: both sums saturate and stay there
    configure(39, 0, 0, $urandom_range(0, 7));
    no_idle = 1'b1;
    for (int unsigned i = 0; i < LongStream; i++) begin
      t         = make_track(1000, -500, 65535 - $urandom_range(0, 7),
                             1000 + int'($urandom_range(0, 600)) - 300,
                             -500 + int'($urandom_range(0, 600)) - 300,
                             $urandom(), i == LongStream - 1);
      t.quality[sb.cfg.quality_select] = 1'b1;
      send_track(t);
    end
    drain();

    // random phases: new settings, then short candidate streams
    phases = 0;
    while (sb.tracks_seen < TrackTarget) begin
      case ($urandom_range(0, 9))
        0:       cone = 0;
        1:       cone = 40;
        2:       cone = $urandom_range(41, 63);
        3:       cone = 1;
        4:       cone = 39;
        default: cone = $urandom_range(1, 39);
      endcase
      case ($urandom_range(0, 5))
        0:       thr = 0;
        1:       thr = 65535;
        2:       thr = $urandom_range(0, 65535);
        default: thr = $urandom_range(0, 1500);
      endcase
      case ($urandom_range(0, 5))
        0:       inner = 0;
        1:       inner = 4095;
        2:       inner = $urandom_range(0, 4095);
        default: inner = $urandom_range(0, cone * 60);
      endcase
      qsel = $urandom_range(0, 7);
      configure(cone, thr, inner, qsel);
      no_idle      = ($urandom_range(0, 3) == 0);
      phase_tracks = 0;
      while (phase_tracks < 40) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        if ($urandom_range(0, 4) == 0) begin
          ceta = 14'($urandom());
          cphi = 13'($urandom());
        end else begin
          ceta = 14'(int'($urandom_range(0, 10240)) - 5120);
          cphi = ($urandom_range(0, 4) == 0) ? 13'(($urandom_range(0, 1) != 0) ? 3217 : -3217)
                                             : 13'(int'($urandom_range(0, 6434)) - 3217);
        end
        for (int unsigned i = 0; i < n; i++) send_track(random_track(ceta, cphi, i == n - 1));
        phase_tracks += n;
      end
      drain();
      phases++;
    end

    $display("Run covered %0d track transfers, %0d candidate results, %0d register writes.",
             sb.tracks_seen, sb.results_seen, cfg_writes);
    $display("Directed edge cases plus %0d random settings phases and a saturating stream.",
             phases);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Timeout: stimulus or results stalled");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tis_pkg.sv
hw/rtl/tis_cfg_regs.sv
hw/rtl/tis_ctrl.sv
hw/rtl/tis_datapath.sv
hw/rtl/track_isolation_sum_unit.sv
hw/rtl/tis_checker.sv
sim/track_isolation_sum_unit_tb.sv
